FILE: rtl/alarm_clock_menu_controller_core_macros.svh
// Assertion macros for the alarm clock menu controller checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ALARM_CLOCK_MENU_CONTROLLER_CORE_MACROS_SVH
`define ALARM_CLOCK_MENU_CONTROLLER_CORE_MACROS_SVH

// Condition must hold at every edge outside reset
`define ACMC_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Trigger in one cycle implies the consequence in the next
`define ACMC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/acmc_pkg.sv
// Shared types and codes for the alarm clock menu controller.
// No dependencies; used by acmc_step, the top level and acmc_checker.
package acmc_pkg;

    // Event kinds
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_BUTTON = 3'd1;
    localparam logic [2:0] MODE_LTIME  = 3'd2;
    localparam logic [2:0] MODE_LALARM = 3'd3;
    localparam logic [2:0] MODE_ENABLE = 3'd4;

    // Buttons
    localparam logic [1:0] BTN_MENU  = 2'd0;
    localparam logic [1:0] BTN_OK    = 2'd1;
    localparam logic [1:0] BTN_PLUS  = 2'd2;
    localparam logic [1:0] BTN_MINUS = 2'd3;

    // Menu states
    localparam logic [1:0] MENU_SHOW = 2'd0;
    localparam logic [1:0] MENU_SETT = 2'd1;
    localparam logic [1:0] MENU_SETA = 2'd2;
    localparam logic [1:0] MENU_RING = 2'd3;

    // Edit field
    localparam logic [1:0] EDIT_NONE = 2'd0;
    localparam logic [1:0] EDIT_HOUR = 2'd1;
    localparam logic [1:0] EDIT_MIN  = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] button;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       enable;
    } t_event;

    typedef struct packed {
        logic [1:0] menu;
        logic [1:0] edit;
        logic [4:0] clk_hour;
        logic [5:0] clk_minute;
        logic [5:0] clk_second;
        logic [4:0] alm_hour;
        logic [5:0] alm_minute;
        logic [4:0] work_hour;
        logic [5:0] work_minute;
        logic       colon;
        logic       visible;
        logic       alarm_on;
        logic       off_flag;
        logic [2:0] off_count;
        logic [6:0] ring_count;
        logic       dismissed;
    } t_state;

    // State after reset: show time, digits visible, everything else clear
    localparam t_state STATE_RESET = '{menu: MENU_SHOW, edit: EDIT_NONE, visible: 1'b1,
                                       default: '0};

    typedef struct packed {
        logic [1:0] menu_mode;
        logic [1:0] edit_field;
        logic [4:0] time_hour;
        logic [5:0] time_minute;
        logic [5:0] time_second;
        logic [4:0] adj_hour;
        logic [5:0] adj_minute;
        logic       colon_on;
        logic       flash_visible;
        logic       off_notice;
        logic       tone_on;
    } t_result;

endpackage

FILE: rtl/acmc_step.sv
// Next-state and result logic for one event of the alarm clock menu controller.
// Depends on acmc_pkg.
module acmc_step #(
    parameter int TICKS_PER_SECOND = 2,
    parameter int RING_TICKS       = 60,
    parameter int OFF_TICKS        = 4,
    parameter int HALF_W           = $clog2(TICKS_PER_SECOND + 1)
) (
    input  acmc_pkg::t_event    i_ev,
    input  acmc_pkg::t_state    i_st,
    input  logic [HALF_W-1:0]   i_half,
    output acmc_pkg::t_state    o_st,
    output logic [HALF_W-1:0]   o_half,
    output acmc_pkg::t_result   o_res
);
    import acmc_pkg::*;

    acmc_pkg::t_state n_st;
    logic [HALF_W-1:0] n_half;

    logic [HALF_W-1:0] half_inc;
    logic [6:0] sec_inc, min_inc;
    logic [5:0] hour_inc;
    logic       sec_carry, min_carry;
    logic [5:0] sec_next, min_next;
    logic [4:0] hour_next;
    logic [5:0] wh_inc;
    logic [4:0] wh_next_up, wh_next_dn;
    logic [6:0] wm_inc;
    logic [5:0] wm_next_up, wm_next_dn;
    logic [2:0] off_inc;
    logic [6:0] ring_dec;
    logic       match;
    logic       to_alarm;

    // Clock advance with carries
    assign half_inc  = i_half + HALF_W'(1);
    assign sec_inc   = {1'b0, i_st.clk_second} + 7'd1;
    assign sec_carry = (sec_inc >= 7'd60);
    assign sec_next  = sec_carry ? 6'd0 : sec_inc[5:0];
    assign min_inc   = {1'b0, i_st.clk_minute} + 7'd1;
    assign min_carry = (min_inc >= 7'd60);
    assign min_next  = min_carry ? 6'd0 : min_inc[5:0];
    assign hour_inc  = {1'b0, i_st.clk_hour} + 6'd1;
    assign hour_next = (hour_inc >= 6'd24) ? 5'(hour_inc - 6'd24) : hour_inc[4:0];

    // Edit wrap values
    assign wh_inc     = {1'b0, i_st.work_hour} + 6'd1;
    assign wh_next_up = (wh_inc >= 6'd24) ? 5'(wh_inc - 6'd24) : wh_inc[4:0];
    assign wh_next_dn = (i_st.work_hour == 5'd0) ? 5'd23 : i_st.work_hour - 5'd1;
    assign wm_inc     = {1'b0, i_st.work_minute} + 7'd1;
    assign wm_next_up = (wm_inc >= 7'd60) ? 6'(wm_inc - 7'd60) : wm_inc[5:0];
    assign wm_next_dn = (i_st.work_minute == 6'd0) ? 6'd59 : i_st.work_minute - 6'd1;

    // Notice and ring counters
    assign off_inc  = i_st.off_count + 3'd1;
    assign ring_dec = (i_st.ring_count != 7'd0) ? i_st.ring_count - 7'd1 : 7'd0;
    assign to_alarm = (i_st.menu == MENU_SETA);

    // Apply one event
    always_comb begin
        n_st  = i_st;
        n_half = i_half;
        match = 1'b0;
        case (i_ev.mode)
            MODE_TICK: begin
                n_st.colon = ~i_st.colon;
                if (half_inc >= HALF_W'(TICKS_PER_SECOND)) begin
                    n_half = '0;
                    n_st.clk_second = sec_next;
                    if (sec_carry) begin
                        n_st.clk_minute = min_next;
                        if (min_carry) begin
                            n_st.clk_hour = hour_next;
                        end
                    end
                end else begin
                    n_half = half_inc;
                end
                if (i_st.off_flag) begin
                    if (off_inc >= 3'(OFF_TICKS)) begin
                        n_st.off_flag  = 1'b0;
                        n_st.off_count = 3'd0;
                        n_st.menu      = MENU_SHOW;
                    end else begin
                        n_st.off_count = off_inc;
                    end
                end else if (i_st.menu == MENU_RING) begin
                    n_st.visible    = ~i_st.visible;
                    n_st.ring_count = ring_dec;
                    if (ring_dec == 7'd0) begin
                        n_st.menu      = MENU_SHOW;
                        n_st.dismissed = 1'b1;
                    end
                end
                match = (n_st.clk_hour == i_st.alm_hour) &&
                        (n_st.clk_minute == i_st.alm_minute);
                if (!match) begin
                    n_st.dismissed = 1'b0;
                end
                if (i_st.alarm_on && n_st.menu != MENU_RING && match && !n_st.dismissed) begin
                    n_st.menu       = MENU_RING;
                    n_st.ring_count = 7'(RING_TICKS);
                end
            end
            MODE_BUTTON: begin
                if (i_st.menu == MENU_RING && i_ev.button == BTN_OK) begin
                    // Dismiss for the rest of this minute
                    n_st.menu      = MENU_SHOW;
                    n_st.dismissed = 1'b1;
                end else if (i_st.off_flag) begin
                    // Drop buttons while the notice shows
                end else if (i_ev.button == BTN_MENU) begin
                    if (i_st.menu == MENU_SHOW) begin
                        n_st.menu = MENU_SETT;
                    end else if (i_st.menu == MENU_SETT) begin
                        n_st.menu = MENU_SETA;
                        if (!i_st.alarm_on) begin
                            n_st.off_flag  = 1'b1;
                            n_st.off_count = 3'd0;
                        end
                    end else begin
                        n_st.menu = MENU_SHOW;
                    end
                end else if ((to_alarm && i_st.alarm_on) || i_st.menu == MENU_SETT) begin
                    case (i_ev.button)
                        BTN_OK: begin
                            if (i_st.edit == EDIT_NONE) begin
                                n_st.edit        = EDIT_HOUR;
                                n_st.work_hour   = to_alarm ? i_st.alm_hour : i_st.clk_hour;
                                n_st.work_minute = to_alarm ? i_st.alm_minute
                                                            : i_st.clk_minute;
                            end else if (i_st.edit == EDIT_HOUR) begin
                                n_st.edit = EDIT_MIN;
                            end else if (i_st.edit == EDIT_MIN) begin
                                if (to_alarm) begin
                                    n_st.alm_hour   = i_st.work_hour;
                                    n_st.alm_minute = i_st.work_minute;
                                end else begin
                                    n_st.clk_hour   = i_st.work_hour;
                                    n_st.clk_minute = i_st.work_minute;
                                    n_st.clk_second = 6'd0;
                                end
                                n_st.edit = EDIT_NONE;
                                n_st.menu = MENU_SHOW;
                            end
                        end
                        BTN_PLUS: begin
                            if (i_st.edit == EDIT_HOUR) begin
                                n_st.work_hour = wh_next_up;
                            end else if (i_st.edit == EDIT_MIN) begin
                                n_st.work_minute = wm_next_up;
                            end
                        end
                        BTN_MINUS: begin
                            if (i_st.edit == EDIT_HOUR) begin
                                n_st.work_hour = wh_next_dn;
                            end else if (i_st.edit == EDIT_MIN) begin
                                n_st.work_minute = wm_next_dn;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            MODE_LTIME: begin
                n_st.clk_hour   = i_ev.hour;
                n_st.clk_minute = i_ev.minute;
                n_st.clk_second = i_ev.second;
            end
            MODE_LALARM: begin
                n_st.alm_hour   = i_ev.hour;
                n_st.alm_minute = i_ev.minute;
            end
            MODE_ENABLE: begin
                n_st.alarm_on = i_ev.enable;
                if (!i_ev.enable && i_st.menu == MENU_RING) begin
                    n_st.menu = MENU_SHOW;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_st   = n_st;
    assign o_half = n_half;

    // Report the state after the event
    assign o_res.menu_mode     = n_st.menu;
    assign o_res.edit_field    = n_st.edit;
    assign o_res.time_hour     = n_st.clk_hour;
    assign o_res.time_minute   = n_st.clk_minute;
    assign o_res.time_second   = n_st.clk_second;
    assign o_res.adj_hour      = n_st.work_hour;
    assign o_res.adj_minute    = n_st.work_minute;
    assign o_res.colon_on      = n_st.colon;
    assign o_res.flash_visible = n_st.visible;
    assign o_res.off_notice    = n_st.off_flag;
    assign o_res.tone_on       = (n_st.menu == MENU_RING);

endmodule

FILE: rtl/alarm_clock_menu_controller_core.sv
// Top level of the alarm clock menu controller: event register, state, result register.
// Depends on acmc_pkg and acmc_step.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-----------------------------------------------
//  event   | i_valid | o_stall | i_mode i_button i_hour i_minute i_second i_enable
//  result  | o_valid | i_stall | o_menu_mode .. o_tone_on (one beat per event)
//
// One event per cycle sustained while the result side is not stalled. An event held
// in the event register is worked as it moves on into the result register. The state
// update is one pass of acmc_step between the two registers.
// Reset: synchronous, active low; clears the clock state and empties both registers.
// A stalled result holds; the event register keeps filling until it too is blocked.
module alarm_clock_menu_controller_core #(
    parameter int TICKS_PER_SECOND = 2,
    parameter int RING_TICKS       = 60,
    parameter int OFF_TICKS        = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_mode,
    input  logic [1:0] i_button,
    input  logic [4:0] i_hour,
    input  logic [5:0] i_minute,
    input  logic [5:0] i_second,
    input  logic       i_enable,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_menu_mode,
    output logic [1:0] o_edit_field,
    output logic [4:0] o_time_hour,
    output logic [5:0] o_time_minute,
    output logic [5:0] o_time_second,
    output logic [4:0] o_edit_hour_out,
    output logic [5:0] o_edit_minute_out,
    output logic       o_colon_on,
    output logic       o_flash_visible,
    output logic       o_off_notice,
    output logic       o_tone_on
);
    import acmc_pkg::*;

    localparam int HALF_W = $clog2(TICKS_PER_SECOND + 1);

    logic              r_in_valid;
    t_event            r_in_ev;
    logic              r_out_valid;
    t_result           r_out;
    t_state            r_st;
    logic [HALF_W-1:0] r_half;

    t_state            n_st;
    logic [HALF_W-1:0] n_half;
    t_result           n_res;
    logic              w_adv;
    logic              w_take;

    // Move the held event into the result register when that register frees up
    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign w_take  = i_valid && !o_stall;

    acmc_step #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND),
        .RING_TICKS      (RING_TICKS),
        .OFF_TICKS       (OFF_TICKS),
        .HALF_W          (HALF_W)
    ) u_step (
        .i_ev  (r_in_ev),
        .i_st  (r_st),
        .i_half(r_half),
        .o_st  (n_st),
        .o_half(n_half),
        .o_res (n_res)
    );

    // Event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_ev <= {i_mode, i_button, i_hour, i_minute, i_second, i_enable};
        end
    end

    // Clock and menu state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= STATE_RESET;
            r_half <= '0;
        end else if (w_adv) begin
            r_st   <= n_st;
            r_half <= n_half;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_menu_mode       = r_out.menu_mode;
    assign o_edit_field      = r_out.edit_field;
    assign o_time_hour       = r_out.time_hour;
    assign o_time_minute     = r_out.time_minute;
    assign o_time_second     = r_out.time_second;
    assign o_edit_hour_out   = r_out.adj_hour;
    assign o_edit_minute_out = r_out.adj_minute;
    assign o_colon_on        = r_out.colon_on;
    assign o_flash_visible   = r_out.flash_visible;
    assign o_off_notice      = r_out.off_notice;
    assign o_tone_on         = r_out.tone_on;

endmodule

FILE: rtl/acmc_checker.sv
// Port-level checks for the alarm clock menu controller, bound to the top level.
// Depends on acmc_pkg and alarm_clock_menu_controller_core_macros.svh.
`include "alarm_clock_menu_controller_core_macros.svh"

module acmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_menu_mode,
    input logic [1:0] o_edit_field,
    input logic [5:0] o_time_minute,
    input logic [5:0] o_time_second,
    input logic       o_tone_on
);
    import acmc_pkg::*;

    logic        w_ring;
    logic        w_edit_ok;
    logic [13:0] w_view;

    // Decode what the result beat shows
    assign w_ring    = (o_menu_mode == MENU_RING);
    assign w_edit_ok = (o_edit_field == EDIT_NONE) || (o_edit_field == EDIT_HOUR) ||
                       (o_edit_field == EDIT_MIN);
    assign w_view    = {o_menu_mode, o_time_minute, o_time_second};

    // Tone tracks the ringing menu state
    `ACMC_ASSERT_NOW(a_tone_ring, !o_valid || (o_tone_on == w_ring), "tone_on disagrees with ring")

    // Edit field never takes the unused code
    `ACMC_ASSERT_NOW(a_edit_code, !o_valid || w_edit_ok, "edit_field out of range")

    // Input side only backs up behind a stalled, full output
    `ACMC_ASSERT_NOW(a_stall_cause, !o_stall || (o_valid && i_stall), "o_stall without stalled beat")

    // Stalled result stays valid and holds its menu mode, minute and second
    `ACMC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(w_view), "stalled beat changed")

endmodule

bind alarm_clock_menu_controller_core acmc_checker u_acmc_checker (.*);
